/* rtl/core/hdrm_pkg.sv */
// Shared types and constants for the host/device range map table.
// Used by the cell row, the top level and the port checker.
// No dependencies.
package hdrm_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int ADDR_BITS     = 48;

	// fixed width of every address-like field on the ports
	localparam int FIELD_W = 48;

	// stream payload layout (same on both sides)
	localparam int PAY_BITS  = 4 * FIELD_W + 2;
	localparam int TDATA_W   = ((PAY_BITS + 7) / 8) * 8;
	localparam int F0_LO     = 0;
	localparam int F1_LO     = FIELD_W;
	localparam int F2_LO     = 2 * FIELD_W;
	localparam int F3_LO     = 3 * FIELD_W;
	localparam int FLAG0_BIT = 4 * FIELD_W;
	localparam int FLAG1_BIT = 4 * FIELD_W + 1;
	localparam int IN_USER_W  = 2;
	localparam int OUT_USER_W = 2;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_FIND   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] host;
		logic [ADDR_BITS-1:0] dev;
		logic [ADDR_BITS-1:0] off;
		logic [ADDR_BITS-1:0] len;
		logic                 pagelocked;
		logic                 registered;
		logic [ADDR_BITS:0]   eb;   // host + off
		logic [ADDR_BITS+1:0] ee;   // host + off + len
	} entry_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		op_t    op;
		logic   match;
		logic   commit;
		entry_t entry;
	} cmd_t;

	function automatic logic [ADDR_BITS-1:0] to_addr(input logic [FIELD_W-1:0] f);
		logic [FIELD_W+ADDR_BITS-1:0] t;
		t = {{ADDR_BITS{1'b0}}, f};
		return t[ADDR_BITS-1:0];
	endfunction

	function automatic logic [FIELD_W-1:0] to_field(input logic [ADDR_BITS-1:0] a);
		logic [FIELD_W+ADDR_BITS-1:0] t;
		t = {{FIELD_W{1'b0}}, a};
		return t[FIELD_W-1:0];
	endfunction

endpackage

/* rtl/core/hdrm_cell.sv */
// One slot of the compacted mapping table, with its match logic.
// Cells form a row: entries shift down from the upper neighbor on remove.
// Depends on hdrm_pkg.
module hdrm_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  hdrm_pkg::cmd_t   cmd,
	input  hdrm_pkg::entry_t up_entry,
	input  logic            up_valid,
	input  logic            dn_valid,
	input  logic            above_in,   // some cell above this one hit
	input  logic            below_in,   // some cell below this one hit
	output logic            valid,
	output logic            above_out,
	output logic            below_out,
	output hdrm_pkg::entry_t sel_entry,
	output hdrm_pkg::entry_t cur_entry  // stored entry, to the lower neighbor
);
	import hdrm_pkg::*;

	entry_t entry_q;
	logic   valid_q;
	logic   hit_q;
	logic   match_d;
	logic   take_up;
	logic   take_new;

	always_comb begin
		case (cmd.op)
			OP_FIND: begin
				match_d = valid_q && (entry_q.eb <= cmd.entry.eb)
					&& (cmd.entry.ee <= entry_q.ee);
			end
			OP_REMOVE: begin
				match_d = valid_q && (entry_q.dev == cmd.entry.dev)
					&& (entry_q.len == cmd.entry.len);
			end
			default: begin
				match_d = 1'b0;
			end
		endcase
	end

	// remove: every slot from the newest hit upward takes its upper neighbor
	assign take_up  = cmd.commit && (cmd.op == OP_REMOVE) && !above_in && (below_in || hit_q);
	// add: first free slot (valid entries are a prefix of the row)
	assign take_new = cmd.commit && (cmd.op == OP_ADD) && !valid_q && dn_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (cmd.match) begin
				hit_q <= match_d;
			end
			if (cmd.commit && (cmd.op == OP_CLEAR)) begin
				valid_q <= 1'b0;
			end else if (take_up) begin
				valid_q <= up_valid;
			end else if (take_new) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_up) begin
			entry_q <= up_entry;
		end else if (take_new) begin
			entry_q <= cmd.entry;
		end
	end

	assign valid     = valid_q;
	assign above_out = above_in || hit_q;
	assign below_out = below_in || hit_q;
	assign sel_entry = (hit_q && !above_in) ? entry_q : '0;
	assign cur_entry = entry_q;

endmodule

/* rtl/core/host_device_range_map_table.sv */
// Top level of the host/device range map table: stream ports, sequencer,
// the row of hdrm_cell slots and the result register. Depends on hdrm_pkg.
//
//   channel   dir  handshake           payload
//   s_*       in   s_tvalid/s_tready   s_tuser = mode, s_tdata = request
//   m_*       out  m_tvalid/m_tready   m_tuser = hit/full, m_tdata = found entry
//
// Every item passes through four steps: accept (host+offset add), span end
// add, parallel compare in all cells, commit. The two span adds are chained.
// A stalled result holds the commit step; the next item is accepted as soon
// as the commit is done, while that result waits in the output register.
// Reset empties the table at once; no clearing pass.
module host_device_range_map_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// host base, device base, offset, size, pagelocked, registered, zero pad
	input  logic [hdrm_pkg::TDATA_W-1:0]      s_tdata,
	// mode
	input  logic [hdrm_pkg::IN_USER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// found host base, found device base, found_offset, found_size,
	// found_pagelocked, found_registered, zero pad
	output logic [hdrm_pkg::TDATA_W-1:0]      m_tdata,
	// hit, table_full
	output logic [hdrm_pkg::OUT_USER_W-1:0]   m_tuser
);
	import hdrm_pkg::*;

	localparam int N = TABLE_ENTRIES;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SPAN   = 4'b0010,
		S_MATCH  = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	state_t state_q;
	op_t    op_q;
	entry_t req_q;
	cmd_t   cmd;
	logic   commit;
	logic   full;
	logic   any_hit;

	logic                  m_tvalid_q;
	logic [TDATA_W-1:0]    m_tdata_q;
	logic [OUT_USER_W-1:0] m_tuser_q;
	logic [TDATA_W-1:0]    res_tdata;
	logic [OUT_USER_W-1:0] res_tuser;

	logic   [N-1:0] valid_vec;
	logic   [N-1:0] above_vec;
	logic   [N-1:0] below_vec;
	entry_t         sel_vec [N];
	entry_t         up_vec  [N];
	entry_t         ent_vec [N];
	entry_t         found;

	assign s_tready = (state_q == S_IDLE);
	assign commit   = (state_q == S_COMMIT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_SPAN;
					end
				end
				S_SPAN: begin
					state_q <= S_MATCH;
				end
				S_MATCH: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q             <= op_t'(s_tuser);
			req_q.host       <= to_addr(s_tdata[F0_LO +: FIELD_W]);
			req_q.dev        <= to_addr(s_tdata[F1_LO +: FIELD_W]);
			req_q.off        <= to_addr(s_tdata[F2_LO +: FIELD_W]);
			req_q.len        <= to_addr(s_tdata[F3_LO +: FIELD_W]);
			req_q.pagelocked <= s_tdata[FLAG0_BIT];
			req_q.registered <= s_tdata[FLAG1_BIT];
			req_q.eb         <= {1'b0, to_addr(s_tdata[F0_LO +: FIELD_W])}
				+ {1'b0, to_addr(s_tdata[F2_LO +: FIELD_W])};
		end
		if (state_q == S_SPAN) begin
			req_q.ee <= {1'b0, req_q.eb} + {2'b00, req_q.len};
		end
	end

	always_comb begin
		cmd.op     = op_q;
		cmd.match  = (state_q == S_MATCH);
		cmd.commit = commit;
		cmd.entry  = req_q;
	end

	for (genvar i = 0; i < N; i++) begin : g_row
		logic up_valid;
		logic dn_valid;
		logic above_in;
		logic below_in;

		if (i == N - 1) begin : g_top
			assign up_vec[i] = '0;
			assign up_valid  = 1'b0;
			assign above_in  = 1'b0;
		end else begin : g_mid
			assign up_vec[i] = ent_vec[i+1];
			assign up_valid  = valid_vec[i+1];
			assign above_in  = above_vec[i+1];
		end
		if (i == 0) begin : g_bot
			assign dn_valid = 1'b1;
			assign below_in = 1'b0;
		end else begin : g_low
			assign dn_valid = valid_vec[i-1];
			assign below_in = below_vec[i-1];
		end

		hdrm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.up_entry  (up_vec[i]),
			.up_valid  (up_valid),
			.dn_valid  (dn_valid),
			.above_in  (above_in),
			.below_in  (below_in),
			.valid     (valid_vec[i]),
			.above_out (above_vec[i]),
			.below_out (below_vec[i]),
			.sel_entry (sel_vec[i]),
			.cur_entry (ent_vec[i])
		);
	end

	assign full    = valid_vec[N-1];
	assign any_hit = below_vec[N-1];

	always_comb begin
		found = '0;
		for (int k = 0; k < N; k++) begin
			found = found | sel_vec[k];
		end
	end

	always_comb begin
		res_tdata = '0;
		res_tuser = '0;
		case (op_q)
			OP_ADD: begin
				res_tuser[0] = !full;
				res_tuser[1] = full;
			end
			OP_REMOVE: begin
				res_tuser[0] = any_hit;
			end
			OP_FIND: begin
				res_tuser[0]                = any_hit;
				res_tdata[F0_LO +: FIELD_W] = to_field(found.host);
				res_tdata[F1_LO +: FIELD_W] = to_field(found.dev);
				res_tdata[F2_LO +: FIELD_W] = to_field(found.off);
				res_tdata[F3_LO +: FIELD_W] = to_field(found.len);
				res_tdata[FLAG0_BIT]        = found.pagelocked;
				res_tdata[FLAG1_BIT]        = found.registered;
			end
			default: begin
				res_tuser = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_tdata_q <= res_tdata;
			m_tuser_q <= res_tuser;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* rtl/core/hdrm_checker.sv */
// Port-level checks for host_device_range_map_table, bound to the top level.
// Depends on hdrm_pkg.
module hdrm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [hdrm_pkg::TDATA_W-1:0]     m_tdata,
	input logic [hdrm_pkg::OUT_USER_W-1:0]  m_tuser
);
	import hdrm_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// hit and table_full never together
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("hit and table_full both set");

	// no hit means no found entry
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata == '0))
		else $error("found fields nonzero without hit");

	// one item at a time: busy right after a transfer in
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after input transfer");

endmodule

bind host_device_range_map_table hdrm_checker u_hdrm_checker (.*);
